// ===== hw/rtl/gps_pkg.sv =====
// ----------------------------------------------------------------------------
// gps_pkg: shared types and constants for the gait phase scheduler
// Holds register indexes, widths, the divider sizing and the structs passed
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package gps_pkg;

   localparam int MAX_FEET     = 8;
   localparam int FOOT_W       = 3;
   localparam int FCNT_W       = 4;
   localparam int PHASE_W      = 16;

   localparam int DIV_NUM_W    = 40;
   localparam int DIV_DEN_W    = 24;
   localparam int DIV_CNT_W    = 6;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;

   typedef enum logic [1:0] {
      CSR_CYCLE_TIME    = 2'd0,
      CSR_DUTY_FACTOR   = 2'd1,
      CSR_PHASE_OFFSETS = 2'd2,
      CSR_FOOT_COUNT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] cycle_time;
      logic [15:0] duty_factor;
      logic [63:0] phase_offsets;
      logic [3:0]  foot_count;
   } cfg_type;

   typedef struct packed {
      logic [FOOT_W-1:0]  foot_index;
      logic [PHASE_W-1:0] foot_phase;
      logic               last_foot;
   } foot_job_type;

endpackage

// ===== hw/rtl/gps_div.sv =====
// ----------------------------------------------------------------------------
// gps_div: restoring divider, one quotient bit per cycle
// Takes a 40-bit dividend and 24-bit divisor; result is held once busy drops.
// ----------------------------------------------------------------------------
module gps_div
   import gps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 busy,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_shift;

   always_comb begin
      busy_in   = busy_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      rem_shift = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         den_in   = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract if it fits
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_shift - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/gps_front.sv =====
// ----------------------------------------------------------------------------
// gps_front: tick intake and gait phase advance
// Accepts a tick, works out the phase increment, updates the gait phase and
// queues one job per foot.
// ----------------------------------------------------------------------------
module gps_front
   import gps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,
   output logic         push,
   output foot_job_type push_job,
   input  logic         queue_full
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_START,
      S_WAIT,
      S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [15:0]          dt_ff, dt_in;
   logic [15:0]          spd_ff, spd_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [DIV_NUM_W-1:0] prod_ff, prod_in;
   logic [FOOT_W-1:0]    idx_ff, idx_in;

   logic [19:0]          num_n;
   logic [23:0]          den_d;
   logic                 moving;
   logic [FCNT_W-1:0]    feet;
   logic                 last;
   logic [7:0]           offset;
   logic                 div_start;
   logic                 div_busy;
   logic [DIV_NUM_W-1:0] div_quo;

   assign num_n  = 20'(cfg.cycle_time) * 20'd10;
   assign den_d  = {(20'(spd_ff) * 20'd10) + 20'd256, 4'b0000};
   assign moving = (23'(spd_ff) * 23'd100) >= 23'd256;
   assign feet   = (cfg.foot_count > FCNT_W'(MAX_FEET)) ? FCNT_W'(MAX_FEET)
                                                        : cfg.foot_count;
   assign last   = (FCNT_W'(idx_ff) + 1'b1) == feet;
   assign offset = cfg.phase_offsets[8*idx_ff +: 8];

   always_comb begin
      state_in  = state_ff;
      dt_in     = dt_ff;
      spd_in    = spd_ff;
      phase_in  = phase_ff;
      prod_in   = prod_ff;
      idx_in    = idx_ff;
      div_start = 1'b0;
      push      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dt_in    = req_tdata[15:0];
               spd_in   = req_tdata[31:16];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            idx_in   = '0;
            state_in = (feet == '0) ? S_IDLE : S_EMIT;
            if (moving) begin
               if ({num_n, 2'b00} + 22'(num_n) < {1'b0, den_d[22:0]} || den_d[23]) begin
                  // clamp to 0.2 s: five times the elapsed time
                  phase_in = phase_ff + PHASE_W'(19'(dt_ff) * 19'd5);
               end else if (num_n > 20'(den_d) && {5'b0, num_n} > {den_d, 1'b0}) begin
                  // clamp to 2 s: half the elapsed time
                  phase_in = phase_ff + PHASE_W'(dt_ff >> 1);
               end else begin
                  prod_in  = 40'(dt_ff) * 40'(den_d);
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (!div_busy) begin
               phase_in = phase_ff + div_quo[PHASE_W-1:0];
               state_in = (feet == '0) ? S_IDLE : S_EMIT;
            end
         end
         S_EMIT: begin
            if (!queue_full) begin
               push   = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
      dt_ff   <= dt_in;
      spd_ff  <= spd_in;
      prod_ff <= prod_in;
   end

   gps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (24'(num_n)),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign req_tready          = (state_ff == S_IDLE);
   assign push_job.foot_index = idx_ff;
   assign push_job.foot_phase = phase_ff + {offset, 8'h00};
   assign push_job.last_foot  = last;

   a_phase_holds_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(phase_ff))
      else $error("gait phase moved while front end idle");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("job pushed into full queue");
   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

// ===== hw/rtl/gps_fifo.sv =====
// ----------------------------------------------------------------------------
// gps_fifo: short job queue between front and back end
// Four entries of foot jobs, first in first out.
// ----------------------------------------------------------------------------
module gps_fifo
   import gps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  foot_job_type push_job,
   input  logic         pop,
   output foot_job_type head_job,
   output logic         full,
   output logic         empty
);

   foot_job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ff, rd_ff;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ff];
   assign count_in = count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/gps_back.sv =====
// ----------------------------------------------------------------------------
// gps_back: per-foot swing/stance classification and progress
// Pops a foot job, divides for progress and holds the result beat.
// ----------------------------------------------------------------------------
module gps_back
   import gps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  foot_job_type head_job,
   input  logic         empty,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast
);

   typedef enum logic {
      B_IDLE,
      B_WAIT
   } state_type;

   state_type            state_ff, state_in;
   foot_job_type         job_ff, job_in;
   logic                 swing_ff, swing_in;
   logic                 ending_ff, ending_in;
   logic                 out_valid_ff, out_valid_in;
   logic [39:0]          out_data_ff, out_data_in;
   logic                 out_last_ff, out_last_in;

   logic [16:0]          swing_len;
   logic                 swing;
   logic [15:0]          into;
   logic [DIV_NUM_W-1:0] dividend;
   logic [DIV_DEN_W-1:0] divisor;
   logic                 div_busy;
   logic [DIV_NUM_W-1:0] div_quo;
   logic [15:0]          progress;
   logic                 slot_free;

   assign swing_len = 17'h10000 - 17'(cfg.duty_factor);
   assign swing     = {1'b0, head_job.foot_phase} < swing_len;
   assign into      = head_job.foot_phase - swing_len[15:0];
   assign dividend  = swing ? {8'b0, head_job.foot_phase, 16'b0} : {8'b0, into, 16'b0};
   assign divisor   = swing ? 24'(swing_len) : 24'(cfg.duty_factor);
   assign progress  = (div_quo > 40'hFFFF) ? 16'hFFFF : div_quo[15:0];
   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      swing_in     = swing_ff;
      ending_in    = ending_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               job_in    = head_job;
               swing_in  = swing;
               ending_in = !swing && ((21'(into) * 21'd20) > (21'(cfg.duty_factor) * 21'd19));
               state_in  = B_WAIT;
            end
         end
         B_WAIT: begin
            if (!div_busy && slot_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {3'b000, ending_ff, progress, swing_ff,
                               job_ff.foot_phase, job_ff.foot_index};
               out_last_in  = job_ff.last_foot;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff      <= job_in;
      swing_ff    <= swing_in;
      ending_ff   <= ending_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   gps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("result beat dropped or changed while stalled");
   a_pop_idle_div: assert property (@(posedge clock) disable iff (reset)
      pop |-> !div_busy)
      else $error("job popped while divider busy");
   a_ending_stance: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_data_ff[36] && out_data_ff[19]))
      else $error("stance ending flagged on a swinging foot");

endmodule

// ===== hw/rtl/gait_phase_scheduler.sv =====
// ----------------------------------------------------------------------------
// gait_phase_scheduler: duty-factor gait phase generator
// One tick in, one result beat per foot out, with a shared phase register.
// ----------------------------------------------------------------------------
// Each tick beat carries the elapsed time and the body speed. The front end
// takes the beat, and when the body moves, it scales the base cycle time by
// speed, clamps it to 0.2..2 s and advances the wrapping gait phase. It then
// queues one job per foot (phase plus that foot's offset). The back end pops
// jobs, classifies each foot as swing or stance against the duty factor and
// returns one result beat per foot, foot 0 first, tlast on the final foot.
// A tick holds the front end through intake and the queueing of one job per
// foot; when the body moves and the cycle time is not clamped, the 40-step
// phase divider runs before the jobs are queued. Each foot result then passes
// through the back end's own 40-step progress divider, which sets the sustained
// rate. A four-entry job queue lets the front end take the next tick while
// results are still draining, and the output register holds a finished beat
// while the consumer stalls. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module gait_phase_scheduler
   import gps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // tick channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] delta_time, [31:16] speed
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] foot_index, [18:3] foot_phase,
                                    // [19] swinging, [35:20] step_progress,
                                    // [36] stance_ending, [39:37] zero
   output logic        rsp_tlast,   // last_foot
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   cfg_type      cfg_ff;
   logic         push;
   foot_job_type push_job;
   foot_job_type head_job;
   logic         pop;
   logic         full;
   logic         empty;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycle_time    <= 16'd4096;
         cfg_ff.duty_factor   <= 16'd39322;
         cfg_ff.phase_offsets <= 64'h8000;
         cfg_ff.foot_count    <= 4'd2;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CYCLE_TIME:    cfg_ff.cycle_time    <= csr_data[15:0];
            CSR_DUTY_FACTOR:   cfg_ff.duty_factor   <= csr_data[15:0];
            CSR_PHASE_OFFSETS: cfg_ff.phase_offsets <= csr_data;
            CSR_FOOT_COUNT:    cfg_ff.foot_count    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // front end: take the tick, advance the phase, queue foot jobs
   gps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_job   (push_job),
      .queue_full (full)
   );

   // decouple the two halves
   gps_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (full),
      .empty    (empty)
   );

   // back end: classify each foot and hold the result beat
   gps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_job   (head_job),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the gait phase scheduler
// Drives tick beats through a bursty driver, predicts every foot result from
// a local copy of the phase state and registers, and compares each result
// beat field by field in a clocked monitor. Registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import gps_pkg::*;

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] delta_time;
   } tick_type;

   typedef struct packed {
      logic [2:0]  foot_index;
      logic [15:0] foot_phase;
      logic        swinging;
      logic [15:0] step_progress;
      logic        stance_ending;
      logic        last_foot;
   } foot_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] delta_time, [31:16] speed
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [2:0] foot_index, [18:3] foot_phase, [19] swinging,
                             // [35:20] step_progress, [36] stance_ending
   logic        rsp_tlast;   // last_foot
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   gait_phase_scheduler DUT (.*);

   // model state
   logic [15:0] mdl_cycle_time;
   logic [15:0] mdl_duty;
   logic [63:0] mdl_offsets;
   logic [3:0]  mdl_feet;
   logic [15:0] mdl_phase;

   tick_type        tick_queue[$];
   foot_result_type foot_expect[$];
   int unsigned     error_count;
   int unsigned     cycle_count;
   int unsigned     hold_off;       // receiver hold-off cycles still to run
   bit              sender_pause;   // stop the driver while set
   bit              beat_taken;     // offered beat accepted at the last edge
   int unsigned     gap_left;
   int unsigned     burst_left;

   localparam int unsigned CYCLE_LIMIT = 2000000;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Advance the gait phase and queue the expected result of each foot.
   function automatic void predict_tick(tick_type t);
      logic [63:0] num, den, inc, swing_len, ph, into, prog, feet;
      foot_result_type r;
      swing_len = 64'd65536 - mdl_duty;
      if (64'(t.speed) * 100 >= 256) begin
         num = 10 * 64'(mdl_cycle_time);
         den = 16 * (10 * 64'(t.speed) + 256);
         if (5 * num < den)      inc = 5 * 64'(t.delta_time);
         else if (num > 2 * den) inc = 64'(t.delta_time) >> 1;
         else                    inc = (64'(t.delta_time) * den) / num;
         mdl_phase = 16'(64'(mdl_phase) + inc);
      end
      feet = (mdl_feet > MAX_FEET) ? MAX_FEET : 64'(mdl_feet);
      for (int i = 0; i < feet; i++) begin
         ph = 64'(16'(64'(mdl_phase) + (((mdl_offsets >> (8 * i)) & 64'hFF) << 8)));
         r = '0;
         r.foot_index = 3'(i);
         r.foot_phase = 16'(ph);
         r.swinging = ph < swing_len;
         if (r.swinging) begin
            prog = (ph << 16) / swing_len;
         end else begin
            into = ph - swing_len;
            prog = (into << 16) / 64'(mdl_duty);
            r.stance_ending = 20 * into > 19 * 64'(mdl_duty);
         end
         r.step_progress = (prog > 64'hFFFF) ? 16'hFFFF : 16'(prog);
         r.last_foot = (i + 1 == feet);
         foot_expect = {foot_expect, r};
      end
   endfunction

   // Driver: bursts of beats with random gaps, fed from tick_queue.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beat_taken) begin
         // previous beat taken, or nothing offered: pick the next one
         beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (!sender_pause && tick_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= tick_queue[0];
            if (burst_left == 0) begin
               burst_left = $urandom_range(12, 1);
               gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Predict on the accepting edge so that register state stays in order.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_tick(req_tdata);
         void'(tick_queue.pop_front());
         beat_taken = 1'b1;
      end
   end

   // Receiver stall pattern: long hold-offs on request, else a random pattern with periodic always-ready windows.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycle_count[9:7] == 3'd5) ? 1'b1 : ($urandom_range(3, 0) != 0);
      end
   end

   // Monitor: compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      foot_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.foot_index    = rsp_tdata[2:0];
         got.foot_phase    = rsp_tdata[18:3];
         got.swinging      = rsp_tdata[19];
         got.step_progress = rsp_tdata[35:20];
         got.stance_ending = rsp_tdata[36];
         got.last_foot     = rsp_tlast;
         if (foot_expect.size() == 0) begin
            $error("unexpected result beat %h", rsp_tdata);
            error_count++;
         end else begin
            want = foot_expect.pop_front();
            if (got.foot_index != want.foot_index) begin
               $error("foot_index expected %0d got %0d", want.foot_index, got.foot_index);
               error_count++;
            end
            if (got.foot_phase != want.foot_phase) begin
               $error("foot_phase expected %0d got %0d", want.foot_phase, got.foot_phase);
               error_count++;
            end
            if (got.swinging != want.swinging) begin
               $error("swinging expected %0d got %0d", want.swinging, got.swinging);
               error_count++;
            end
            if (got.step_progress != want.step_progress) begin
               $error("step_progress expected %0d got %0d",
                      want.step_progress, got.step_progress);
               error_count++;
            end
            if (got.stance_ending != want.stance_ending) begin
               $error("stance_ending expected %0d got %0d",
                      want.stance_ending, got.stance_ending);
               error_count++;
            end
            if (got.last_foot != want.last_foot) begin
               $error("last_foot expected %0d got %0d", want.last_foot, got.last_foot);
               error_count++;
            end
         end
      end
   end

   // Cycle limit: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Write one register while idle and mirror it in the model.
   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CYCLE_TIME:    mdl_cycle_time = value[15:0];
         CSR_DUTY_FACTOR:   mdl_duty = value[15:0];
         CSR_PHASE_OFFSETS: mdl_offsets = value;
         CSR_FOOT_COUNT:    mdl_feet = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold until every tick is taken and every result returned, then settle.
   task automatic drain();
      while (tick_queue.size() != 0 || req_tvalid || foot_expect.size() != 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic add_tick(logic [15:0] dt, logic [15:0] spd);
      tick_type t;
      t.delta_time = dt;
      t.speed = spd;
      tick_queue = {tick_queue, t};
   endtask

   // Random tick: mostly moving, with extremes mixed in.
   task automatic add_random_ticks(int count);
      logic [15:0] spd;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(5, 0))
            0:       spd = 16'($urandom_range(3, 0));          // around the still threshold
            1:       spd = 16'($urandom);
            2:       spd = 16'($urandom_range(65535, 65000));
            default: spd = 16'($urandom_range(1024, 2));
         endcase
         add_tick(($urandom_range(7, 0) == 0) ? 16'hFFFF : 16'($urandom), spd);
      end
   endtask

   initial begin
      logic [15:0] ct_set[6] = '{16'd1, 16'd65535, 16'd4096, 16'd0, 16'd800, 16'd20000};
      logic [15:0] df_set[6] = '{16'd1, 16'd65535, 16'd39322, 16'd0, 16'd32768, 16'd50000};
      logic [3:0]  fc_set[6] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd6};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CYCLE_TIME;
      csr_data = '0;
      error_count = 0;
      cycle_count = 0;
      hold_off = 0;
      sender_pause = 1'b0;
      beat_taken = 1'b0;
      gap_left = 0;
      burst_left = 0;
      mdl_cycle_time = 16'd4096;
      mdl_duty = 16'd39322;
      mdl_offsets = 64'd32768;
      mdl_feet = 4'd2;
      mdl_phase = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, field extremes, still threshold, clamps
      add_tick(16'd0, 16'd0);
      add_tick(16'hFFFF, 16'd2);
      add_tick(16'hFFFF, 16'd3);
      add_tick(16'hFFFF, 16'hFFFF);
      add_tick(16'h5555, 16'hAAAA);
      add_tick(16'hAAAA, 16'h5555);
      add_tick(16'd1000, 16'd256);
      add_tick(16'd40000, 16'd3);
      drain();

      // phases through register settings, extremes among them
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_CYCLE_TIME, 64'(ct_set[p]));
         write_reg(CSR_DUTY_FACTOR, 64'(df_set[p]));
         write_reg(CSR_PHASE_OFFSETS,
                   (p == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
         write_reg(CSR_FOOT_COUNT, 64'(fc_set[p]));
         if (p == 0) begin
            add_tick(16'hFFFF, 16'd700);
            add_tick(16'd0, 16'hFFFF);
         end
         add_random_ticks(62);
         if (p == 2) begin
            // long receiver hold-off while the sender keeps offering beats
            hold_off = 3000;
         end
         if (p == 4) begin
            // sender pauses mid-phase until every result has come back
            while (tick_queue.size() > 30) @(posedge clock);
            sender_pause = 1'b1;
            while (req_tvalid || foot_expect.size() != 0) @(posedge clock);
            sender_pause = 1'b0;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
